### design/ppmm_pkg.sv
// ----------------------------------------------------------------------------
// ppmm_pkg
// shared widths, port decode constants and item layout for the paging mapper
// ----------------------------------------------------------------------------
package ppmm_pkg;

	localparam int PortW     = 16;
	localparam int ByteW     = 8;
	localparam int PageW     = 11;
	localparam int Slot0W    = 2;
	localparam int ScreenW   = 3;
	localparam int InDataW   = 32;
	localparam int OutDataW  = 24;

	// paging port decode: hit when (port & mask) == (value & mask)
	localparam logic [PortW-1:0] MaskShort  = 16'hC007;
	localparam logic [PortW-1:0] MaskFull   = 16'hFFFF;
	localparam logic [PortW-1:0] PortExtMem = 16'h1FFD;
	localparam logic [PortW-1:0] PortPage   = 16'h7FFD;
	localparam logic [PortW-1:0] PortExtra  = 16'hEFF7;

	// bit positions inside the paging registers
	localparam int ExtRamBit    = 0;
	localparam int ExtRom0Bit   = 1;
	localparam int ExtAltRomBit = 3;
	localparam int PageScrBit   = 3;
	localparam int PageRomBit   = 4;
	localparam int PageLockBit  = 5;
	localparam int ExtraDosBit  = 7;

	localparam logic [ScreenW-1:0] ScreenNormal = 3'd5;
	localparam logic [ScreenW-1:0] ScreenShadow = 3'd7;

	typedef enum logic {
		OP_REFRESH = 1'b0,
		OP_WRITE   = 1'b1
	} op_t;

	typedef struct packed {
		logic [ByteW-1:0] ext_mem;
		logic [ByteW-1:0] page;
		logic [ByteW-1:0] extra_ctrl;
		logic             rom_select;
	} paging_state_t;

	// result item, last field in the lowest bits
	typedef struct packed {
		logic [OutDataW-21:0] pad;
		logic                 write_taken;
		logic                 dos_forced;
		logic                 paging_locked;
		logic [ScreenW-1:0]   screen_page;
		logic [PageW-1:0]     top_page;
		logic [Slot0W-1:0]    slot0_page;
		logic                 slot0_is_ram;
	} result_t;

	function automatic logic port_hit(
		input logic [PortW-1:0] port,
		input logic [PortW-1:0] mask,
		input logic [PortW-1:0] value
	);
		return (port & mask) == (value & mask);
	endfunction

endpackage

### design/paging_port_memory_mapper_unit.sv
// ----------------------------------------------------------------------------
// paging_port_memory_mapper_unit
// paging registers of a banked 8-bit machine, driven by i/o port writes
// ----------------------------------------------------------------------------
// usage:
//  - slave channel carries one transaction per cpu bus event: tuser is the
//    kind (refresh or port write), tdata holds port address, data byte and
//    the live disk-rom flag
//  - port writes are decoded against 1FFD, 7FFD (mask C007) and EFF7 (full
//    decode), first hit wins; 7FFD is ignored once its lock bit is set
//  - master channel returns one transaction per input with the memory map
//    after that input: slot 0 ram/rom and page, top slot page, screen page,
//    lock bit, forced disk flag and whether the write was taken
//  - pipeline: one input register and one result register
//  - throughput: one transaction per cycle while the master keeps up; the input
//    register moves on whenever the result register is empty or being drained
//  - a stalled master holds the result register and the input register
//    still takes one more transaction before s_axis_tready drops
//  - reset clears all paging registers (rom 2 in slot 0 with the disk flag clear,
//    screen page 5, unlocked) and empties both pipeline registers
// ----------------------------------------------------------------------------
module paging_port_memory_mapper_unit
	import ppmm_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	// [15:0] port_addr, [23:16] write_data, [24] dos_active, [31:25] zero
	input  logic [InDataW-1:0]  s_axis_tdata,
	// [0] op
	input  logic                s_axis_tuser,
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	// [0] slot0_is_ram, [2:1] slot0_page, [13:3] top_page, [16:14] screen_page,
	// [17] paging_locked, [18] dos_forced, [19] write_taken, [23:20] zero
	output logic [OutDataW-1:0] m_axis_tdata
);

	// input register
	logic             valid_s1;
	op_t              op_s1;
	logic [PortW-1:0] port_s1;
	logic [ByteW-1:0] data_s1;
	logic             dos_s1;

	// result register
	logic             out_valid_q;
	result_t          result_q;

	// paging state
	paging_state_t    state_q;
	paging_state_t    state_next;

	logic             advance;
	logic             hit_ext;
	logic             hit_page;
	logic             hit_extra;
	logic             taken;
	result_t          result_next;

	// the input stage hands over when the result slot is free
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			op_s1   <= op_t'(s_axis_tuser);
			port_s1 <= s_axis_tdata[PortW-1:0];
			data_s1 <= s_axis_tdata[PortW+ByteW-1:PortW];
			dos_s1  <= s_axis_tdata[PortW+ByteW];
		end
	end

	// port decode, first match wins
	always_comb begin
		hit_ext    = port_hit(port_s1, MaskShort, PortExtMem);
		hit_page   = !hit_ext && port_hit(port_s1, MaskShort, PortPage);
		hit_extra  = !hit_ext && !hit_page && port_hit(port_s1, MaskFull, PortExtra);
		state_next = state_q;
		taken      = 1'b0;
		if (op_s1 == OP_WRITE) begin
			if (hit_ext) begin
				state_next.ext_mem = data_s1;
				taken              = 1'b1;
			end else if (hit_page && !state_q.page[PageLockBit]) begin
				state_next.page       = data_s1;
				state_next.rom_select = data_s1[PageRomBit];
				taken                 = 1'b1;
			end else if (hit_extra) begin
				state_next.extra_ctrl = data_s1;
				taken                 = 1'b1;
			end
		end
	end

	// memory map from the updated registers
	always_comb begin
		result_next               = '0;
		result_next.write_taken   = taken;
		result_next.dos_forced    = state_next.extra_ctrl[ExtraDosBit];
		result_next.paging_locked = state_next.page[PageLockBit];
		result_next.screen_page   = state_next.page[PageScrBit] ? ScreenShadow : ScreenNormal;
		// top page is assembled from scattered register bits
		result_next.top_page      = {state_next.page[7], 1'b0,
			state_next.ext_mem[7:6], 1'b0, state_next.ext_mem[4], 2'b00,
			state_next.page[2:0]};
		if (state_next.ext_mem[ExtRamBit]) begin
			result_next.slot0_is_ram = 1'b1;
			result_next.slot0_page   = 2'd0;
		end else if (state_next.ext_mem[ExtRom0Bit]) begin
			result_next.slot0_page   = 2'd0;
		end else if (state_next.ext_mem[ExtAltRomBit]) begin
			// alternate rom set
			result_next.slot0_page   = dos_s1 ? 2'd3 :
				(state_next.rom_select ? 2'd1 : 2'd0);
		end else begin
			// normal rom set
			result_next.slot0_page   = dos_s1 ? 2'd1 :
				(state_next.rom_select ? 2'd3 : 2'd2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				state_q     <= state_next;
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result_next;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = result_q;

	// lock bit holds until reset
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q.page[PageLockBit] |=> state_q.page[PageLockBit])
		else $error("paging lock bit cleared without reset");

	// rom select always follows the stored 7FFD value
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q.rom_select == state_q.page[PageRomBit])
		else $error("rom select out of step with page register");

	// a fresh result only comes from a held input transaction
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s1))
		else $error("result produced without input");

	// paging state only moves when a transaction advances
	assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(state_q))
		else $error("paging state changed while idle");

	// screen page is always one of the two screens
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (result_q.screen_page == ScreenNormal ||
			result_q.screen_page == ScreenShadow))
		else $error("invalid screen page");

endmodule

### test/ppmm_mapping_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppmm_mapping_checker
// follows both streams of the paging mapper, tracks its paging registers and
// compares every result transaction with the mapping expected after its input
// ----------------------------------------------------------------------------
module ppmm_mapping_checker
	import ppmm_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	input  logic                s_tready,
	input  logic [InDataW-1:0]  s_tdata,
	input  logic                s_tuser,
	input  logic                m_tvalid,
	input  logic                m_tready,
	input  logic [OutDataW-1:0] m_tdata,
	output int                  fail_count,
	output int                  pending,
	output int                  checked,
	output int                  taken_writes
);

	paging_state_t regs;
	result_t       expected_maps[$];
	result_t       got;
	result_t       want;

	task automatic flag_error(input string msg);
		$display("%0t ns: result %0d: %s", $time, checked, msg);
		fail_count++;
	endtask

	task automatic check_field(input string name, input logic [15:0] seen, input logic [15:0] ref_val);
		if (seen !== ref_val) begin
			flag_error($sformatf("%s is %0h, expected %0h", name, seen, ref_val));
		end
	endtask

	// applies one bus event to the tracked registers, returns the mapping after it
	function automatic result_t next_mapping(
		input op_t              op,
		input logic [PortW-1:0] port,
		input logic [ByteW-1:0] data,
		input logic             dos
	);
		result_t r;
		logic    hit_ext;
		logic    hit_page;
		logic    hit_extra;
		r = '0;
		hit_ext   = (port & MaskShort) == (PortExtMem & MaskShort);
		hit_page  = (port & MaskShort) == (PortPage & MaskShort);
		hit_extra = port == PortExtra;
		if (op == OP_WRITE) begin
			if (hit_ext) begin
				regs.ext_mem = data;
				r.write_taken = 1'b1;
			end else if (hit_page) begin
				if (!regs.page[PageLockBit]) begin
					regs.page = data;
					regs.rom_select = data[PageRomBit];
					r.write_taken = 1'b1;
				end
			end else if (hit_extra) begin
				regs.extra_ctrl = data;
				r.write_taken = 1'b1;
			end
		end

		// top slot page gathered from scattered register bits
		r.top_page = {regs.page[7], 1'b0, regs.ext_mem[7:6], 1'b0, regs.ext_mem[4],
			2'b00, regs.page[2:0]};

		if (regs.ext_mem[ExtRamBit]) begin
			r.slot0_is_ram = 1'b1;
			r.slot0_page = 2'd0;
		end else if (regs.ext_mem[ExtRom0Bit]) begin
			r.slot0_page = 2'd0;
		end else if (regs.ext_mem[ExtAltRomBit]) begin
			r.slot0_page = dos ? 2'd3 : (regs.rom_select ? 2'd1 : 2'd0);
		end else begin
			r.slot0_page = dos ? 2'd1 : (regs.rom_select ? 2'd3 : 2'd2);
		end

		r.screen_page = regs.page[PageScrBit] ? ScreenShadow : ScreenNormal;
		r.paging_locked = regs.page[PageLockBit];
		r.dos_forced = regs.extra_ctrl[ExtraDosBit];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs = '0;
			expected_maps.delete();
			pending = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (expected_maps.size() == 0) begin
					flag_error($sformatf("result %0h arrived with nothing expected", m_tdata));
				end else begin
					want = expected_maps.pop_front();
					check_field("slot0_is_ram", got.slot0_is_ram, want.slot0_is_ram);
					check_field("slot0_page", got.slot0_page, want.slot0_page);
					check_field("top_page", got.top_page, want.top_page);
					check_field("screen_page", got.screen_page, want.screen_page);
					check_field("paging_locked", got.paging_locked, want.paging_locked);
					check_field("dos_forced", got.dos_forced, want.dos_forced);
					check_field("write_taken", got.write_taken, want.write_taken);
					check_field("padding", got.pad, want.pad);
					checked++;
				end
			end
			if (s_tvalid && s_tready) begin
				want = next_mapping(op_t'(s_tuser), s_tdata[15:0], s_tdata[23:16], s_tdata[24]);
				expected_maps.push_back(want);
				if (want.write_taken) begin
					taken_writes++;
				end
			end
			pending = expected_maps.size();
		end
	end

endmodule

### test/tb_paging_port_memory_mapper_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_paging_port_memory_mapper_unit
// drives refreshes and port writes into the paging mapper under varying
// backpressure and lets the checker compare every mapping it returns
// ----------------------------------------------------------------------------
module tb_paging_port_memory_mapper_unit
	import ppmm_pkg::*;
();

	localparam int CycleLimit    = 200_000; // several times the slowest legal run
	localparam int HoldOffCycles = 80;      // long master stall to fill the pipeline
	localparam int DrainCycles   = 8;       // margin after the drain to catch stray results

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	// [15:0] port_addr, [23:16] write_data, [24] dos_active, [31:25] zero
	logic [InDataW-1:0]  s_tdata = '0;
	// [0] op
	logic                s_tuser = 1'b0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	// [0] slot0_is_ram, [2:1] slot0_page, [13:3] top_page, [16:14] screen_page,
	// [17] paging_locked, [18] dos_forced, [19] write_taken, [23:20] zero
	logic [OutDataW-1:0] m_tdata;

	int fail_count;
	int pending;
	int checked;
	int taken_writes;

	// idling knobs shared by the sender and the receiver
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	bit hold_off_req   = 1'b0;

	int cycle_cnt = 0;
	int n_sent    = 0;
	int n_refresh = 0;
	int hold_cnt;

	paging_port_memory_mapper_unit DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_tvalid),
		.s_axis_tready (s_tready),
		.s_axis_tdata  (s_tdata),
		.s_axis_tuser  (s_tuser),
		.m_axis_tvalid (m_tvalid),
		.m_axis_tready (m_tready),
		.m_axis_tdata  (m_tdata)
	);

	ppmm_mapping_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.fail_count   (fail_count),
		.pending      (pending),
		.checked      (checked),
		.taken_writes (taken_writes)
	);

	// 20 ns clock
	initial begin
		forever begin
			#10 clk = ~clk;
		end
	end

	// watchdog: a hung handshake ends the run here
	initial begin
		while (cycle_cnt < CycleLimit) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("paging_port_memory_mapper_unit verification failed");
		$finish;
	end

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				m_tready <= 1'b0;
				for (hold_cnt = 0; hold_cnt < HoldOffCycles; hold_cnt++) begin
					@(posedge clk);
				end
			end else begin
				m_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// offers one transaction after a random gap and waits for its handshake;
	// tvalid stays high on return so back-to-back items need no extra step
	task automatic send_item(
		input op_t              op,
		input logic [PortW-1:0] port,
		input logic [ByteW-1:0] data,
		input logic             dos
	);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {7'd0, dos, data, port};
		do begin
			@(posedge clk);
		end while (!s_tready);
		n_sent++;
		if (op == OP_REFRESH) begin
			n_refresh++;
		end
	endtask

	// mostly well-formed hits on the three paging ports with random alias bits,
	// the rest near misses, random ports and refreshes; before the lock phase
	// the lock bit of 7FFD writes is kept clear so paging stays open
	task automatic send_random_item(input bit lock_ok);
		op_t              op;
		logic [PortW-1:0] port;
		logic [ByteW-1:0] data;
		int               pick;
		op   = ($urandom_range(99) < 85) ? OP_WRITE : OP_REFRESH;
		data = 8'($urandom_range(255));
		pick = $urandom_range(99);
		if (pick < 30) begin
			port = (16'($urandom_range(16'hFFFF)) & ~MaskShort) | (PortExtMem & MaskShort);
		end else if (pick < 60) begin
			port = (16'($urandom_range(16'hFFFF)) & ~MaskShort) | (PortPage & MaskShort);
		end else if (pick < 75) begin
			port = PortExtra;
		end else if (pick < 85) begin
			port = PortExtra ^ (16'h1 << $urandom_range(15));
		end else begin
			port = 16'($urandom_range(16'hFFFF));
		end
		if (!lock_ok && ((port & MaskShort) == (PortPage & MaskShort))) begin
			data[PageLockBit] = 1'b0;
		end
		send_item(op, port, data, 1'($urandom_range(1)));
	endtask

	task automatic run_phase(input int idle, input int stall, input int count, input bit lock_ok);
		send_idle_pct  = idle;
		recv_stall_pct = stall;
		repeat (count) begin
			send_random_item(lock_ok);
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset mapping, refresh with write-like fields, extreme ports
		send_item(OP_REFRESH, 16'h0000, 8'h00, 1'b0);
		send_item(OP_REFRESH, 16'hFFFF, 8'hFF, 1'b1);
		send_item(OP_WRITE, 16'h0000, 8'hFF, 1'b0);
		send_item(OP_WRITE, 16'hFFFF, 8'hFF, 1'b1);
		// full decode of EFF7 and a one-bit near miss
		send_item(OP_WRITE, PortExtra, 8'h80, 1'b0);
		send_item(OP_WRITE, 16'hEFF6, 8'h00, 1'b0);
		send_item(OP_WRITE, PortExtra, 8'h00, 1'b1);
		// 7FFD with rom select, shadow screen and top page bits, no lock
		send_item(OP_WRITE, PortPage, 8'h9F, 1'b0);
		// slot 0 rom choice across all branches with rom select and disk flag
		send_item(OP_WRITE, PortExtMem, 8'h00, 1'b0);
		send_item(OP_REFRESH, 16'h1234, 8'h55, 1'b1);
		send_item(OP_WRITE, PortExtMem, 8'h08, 1'b0);
		send_item(OP_REFRESH, 16'hABCD, 8'hAA, 1'b1);
		send_item(OP_WRITE, 16'h4005, 8'h00, 1'b0);
		send_item(OP_WRITE, PortExtMem, 8'h08, 1'b0);
		send_item(OP_WRITE, 16'h0005, 8'h00, 1'b0);
		send_item(OP_WRITE, PortExtMem, 8'h02, 1'b1);
		send_item(OP_WRITE, PortExtMem, 8'h03, 1'b1);
		send_item(OP_WRITE, PortExtMem, 8'hD0, 1'b0);
		send_item(OP_WRITE, PortExtMem, 8'hFF, 1'b0);
		send_item(OP_WRITE, PortPage, 8'hDF, 1'b0);
		// ports that only look close to the short decode
		send_item(OP_WRITE, 16'hBFFD, 8'h3C, 1'b0);
		send_item(OP_WRITE, 16'hFFFD, 8'hC3, 1'b1);

		// random phases with different idling mixes
		run_phase(0, 0, 400, 1'b0);
		run_phase(47, 0, 400, 1'b0);
		run_phase(0, 47, 400, 1'b0);
		run_phase(7, 7, 400, 1'b0);

		// long receiver hold-off while the sender keeps offering
		hold_off_req = 1'b1;
		run_phase(0, 0, 60, 1'b0);

		// lock 7FFD, then show it refuses writes while the other ports still work
		send_item(OP_WRITE, PortPage, 8'h3A, 1'b0);
		send_item(OP_WRITE, PortPage, 8'h00, 1'b1);
		send_item(OP_WRITE, 16'h4005, 8'hFF, 1'b0);
		send_item(OP_WRITE, PortExtMem, 8'h01, 1'b0);
		send_item(OP_REFRESH, PortPage, 8'h00, 1'b1);
		run_phase(20, 20, 80, 1'b1);
		s_tvalid <= 1'b0;

		// drain: wait until every sent transaction has been checked,
		// then hold for the drain margin to catch stray results
		while (pending != 0 || checked != n_sent) begin
			@(posedge clk);
		end
		repeat (DrainCycles) @(posedge clk);

		$display("run covered %0d transactions (%0d refreshes) and %0d checked mappings",
			n_sent, n_refresh, checked);
		$display("paging register writes taken: %0d, 7FFD lock exercised at the end",
			taken_writes);
		if (fail_count == 0 && checked == n_sent) begin
			$display("paging_port_memory_mapper_unit verification clean");
		end else begin
			$display("paging_port_memory_mapper_unit verification failed");
		end
		$finish;
	end

endmodule
